// File: design/pcxb_pkg.sv
// Shared types and constants for the x-band polyline clipper.
// No dependencies; imported by pcxb_interp and polyline_clip_x_band.
`timescale 1ns / 1ps
`default_nettype none

package pcxb_pkg;

  localparam int COORD_BITS   = 32;
  localparam int PROD_BITS    = 2 * COORD_BITS;
  localparam int TDATA_BITS   = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int CNT_BITS     = $clog2(2 * COORD_BITS + 1);
  localparam int CFG_IDX_BITS = 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] mag_t;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BAND_LOW  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_BAND_HIGH = CFG_IDX_BITS'(1);

  // reset bounds: -180.0 and +180.0 in Q9.22
  localparam coord_t BAND_LOW_RST  = -COORD_BITS'(754974720);
  localparam coord_t BAND_HIGH_RST = COORD_BITS'(754974720);

  // interpolation request: y = py + trunc((cy-py)*(bnd-px)/(cx-px))
  typedef struct packed {
    logic   start;
    coord_t px;
    coord_t py;
    coord_t cx;
    coord_t cy;
    coord_t bnd;
  } interp_req_t;

  typedef struct packed {
    logic   busy;
    logic   valid;  // result held until the next start
    coord_t y;
  } interp_resp_t;

endpackage

`default_nettype wire

// File: design/polyline_clip_x_band.sv
// Path: a pass-through point is evaluated and then loaded into the output register; a crossing
//   point goes through evaluate, multiply, divider setup, divider steps, finish, handoff, output load.
// Throughput: one item at a time; an entry or exit waits on the serial divider, and
//   output stalls hold the flow.
// Reset: rst_n synchronous, active low; clears state, bounds return to -180.0/+180.0.
// Depends on pcxb_pkg and pcxb_interp. Next item is taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module polyline_clip_x_band import pcxb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [TDATA_BITS-1:0]   in_tdata,   // pos_x, pos_y
  input  logic                    in_tuser,   // is_gap
  input  logic                    in_tlast,   // end_of_set
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [TDATA_BITS-1:0]   out_tdata,  // out_x, out_y
  output logic                    out_tuser,  // out_gap
  output logic                    out_tlast,  // last_of_burst
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_GAP   = 6'b000100,  // emit pending break marker
    S_CALC  = 6'b001000,  // wait for interpolator
    S_CROSS = 6'b010000,  // emit entry/exit point
    S_POINT = 6'b100000   // emit the inside point itself
  } st_t;

  st_t    state_r, state_nxt;
  coord_t band_low_r, band_high_r;
  coord_t itm_x_r, itm_y_r;
  logic   itm_gap_r, itm_eos_r;
  coord_t prior_x_r, prior_y_r;
  logic   prior_valid_r, prior_inside_r, gap_pending_r;
  logic   do_cross_r, do_pt_r;
  coord_t bnd_r;
  logic   out_valid_r, out_gap_r, out_last_r;
  coord_t out_x_r, out_y_r;

  interp_req_t  ireq;
  interp_resp_t iresp;

  logic   in_band, run_on, is_pt, do_gap, entry, exits;
  coord_t bnd_sel;
  logic   emit_go, load;

  // item classification, valid in S_EVAL
  assign in_band = (itm_x_r >= band_low_r) && (itm_x_r <= band_high_r);
  assign run_on  = prior_valid_r && prior_inside_r;
  assign is_pt   = !itm_gap_r;
  assign do_gap  = is_pt && in_band && !run_on && gap_pending_r;
  assign entry   = is_pt && in_band && !run_on && prior_valid_r;
  assign exits   = is_pt && !in_band && run_on;
  // entry crosses the bound on the prior point's side, exit on the new point's
  assign bnd_sel = entry ? ((prior_x_r < band_low_r) ? band_low_r : band_high_r)
                         : ((itm_x_r < band_low_r) ? band_low_r : band_high_r);

  assign ireq.start = (state_r == S_EVAL) && (entry || exits);
  assign ireq.px    = prior_x_r;
  assign ireq.py    = prior_y_r;
  assign ireq.cx    = itm_x_r;
  assign ireq.cy    = itm_y_r;
  assign ireq.bnd   = bnd_sel;

  pcxb_interp u_interp (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ireq),
    .resp (iresp)
  );

  // one-deep output register
  assign emit_go = !out_valid_r || out_tready;
  assign load    = emit_go &&
                   (state_r == S_GAP || state_r == S_CROSS || state_r == S_POINT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EVAL;
      S_EVAL: begin
        if (do_gap)                state_nxt = S_GAP;
        else if (entry || exits)   state_nxt = S_CALC;
        else if (is_pt && in_band) state_nxt = S_POINT;
        else                       state_nxt = S_IDLE;
      end
      S_GAP: if (emit_go) begin
        if (do_cross_r)   state_nxt = S_CALC;
        else if (do_pt_r) state_nxt = S_POINT;
        else              state_nxt = S_IDLE;
      end
      S_CALC:  if (iresp.valid) state_nxt = S_CROSS;
      S_CROSS: if (emit_go) state_nxt = do_pt_r ? S_POINT : S_IDLE;
      S_POINT: if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      band_low_r     <= BAND_LOW_RST;
      band_high_r    <= BAND_HIGH_RST;
      prior_x_r      <= '0;
      prior_y_r      <= '0;
      prior_valid_r  <= 1'b0;
      prior_inside_r <= 1'b0;
      gap_pending_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_BAND_LOW:  band_low_r  <= cfg_data;
          REG_BAND_HIGH: band_high_r <= cfg_data;
          default: ;
        endcase
      end

      // run state moves on in S_EVAL; interpolator has latched the old prior point
      if (state_r == S_EVAL) begin
        if (itm_eos_r) begin
          prior_x_r      <= '0;
          prior_y_r      <= '0;
          prior_valid_r  <= 1'b0;
          prior_inside_r <= 1'b0;
          gap_pending_r  <= 1'b0;
        end else if (itm_gap_r) begin
          if (run_on) gap_pending_r <= 1'b1;
          prior_valid_r  <= 1'b0;
          prior_inside_r <= 1'b0;
        end else begin
          prior_x_r      <= itm_x_r;
          prior_y_r      <= itm_y_r;
          prior_valid_r  <= 1'b1;
          prior_inside_r <= in_band;
          if (do_gap)     gap_pending_r <= 1'b0;
          else if (exits) gap_pending_r <= 1'b1;
        end
      end

      if (load)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      itm_x_r   <= in_tdata[COORD_BITS-1:0];
      itm_y_r   <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      itm_gap_r <= in_tuser;
      itm_eos_r <= in_tlast;
    end
    if (state_r == S_EVAL) begin
      do_cross_r <= entry || exits;
      do_pt_r    <= is_pt && in_band;
      bnd_r      <= bnd_sel;
    end
    if (load) begin
      unique case (state_r)
        S_GAP: begin
          out_x_r    <= '0;
          out_y_r    <= '0;
          out_gap_r  <= 1'b1;
          out_last_r <= !(do_cross_r || do_pt_r);
        end
        S_CROSS: begin
          out_x_r    <= bnd_r;
          out_y_r    <= iresp.y;
          out_gap_r  <= 1'b0;
          out_last_r <= !do_pt_r;
        end
        default: begin
          out_x_r    <= itm_x_r;
          out_y_r    <= itm_y_r;
          out_gap_r  <= 1'b0;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_BITS'({out_y_r, out_x_r});
  assign out_tuser  = out_gap_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ireq.start |-> !iresp.busy)
    else $error("interpolator started while busy");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !iresp.busy)
    else $error("item accepted during interpolation");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("break marker with nonzero coordinates");

  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && itm_eos_r) |=> (!prior_valid_r && !gap_pending_r))
    else $error("state not cleared after end of set");
`endif

endmodule

`default_nettype wire

// File: design/pcxb_interp.sv
// Crossing interpolator: one 32x32 multiply, then a radix-2 restoring divider.
// Depends on pcxb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcxb_interp import pcxb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  interp_req_t  req,
  output interp_resp_t resp
);

  typedef enum logic [4:0] {
    I_IDLE = 5'b00001,
    I_MUL  = 5'b00010,
    I_PREP = 5'b00100,
    I_DIV  = 5'b01000,
    I_FIN  = 5'b10000
  } ist_t;

  ist_t                  state_r, state_nxt;
  mag_t                  mdy_r, mnum_r, mden_r;
  logic                  neg_r;
  coord_t                py_r;
  logic [PROD_BITS-1:0]  prod_r;
  logic [PROD_BITS-1:0]  dvd_r;
  mag_t                  rem_r;
  mag_t                  q_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  valid_r;
  coord_t                y_r;

  logic [COORD_BITS:0]   d_dy, d_num, d_den;
  logic [COORD_BITS:0]   rem_sh;
  logic                  ge;
  mag_t                  hi_w;

  // signed differences, one bit wider, then magnitude and sign
  assign d_dy  = {req.cy[COORD_BITS-1], req.cy} - {req.py[COORD_BITS-1], req.py};
  assign d_num = {req.bnd[COORD_BITS-1], req.bnd} - {req.px[COORD_BITS-1], req.px};
  assign d_den = {req.cx[COORD_BITS-1], req.cx} - {req.px[COORD_BITS-1], req.px};

  function automatic mag_t mag_of(input logic [COORD_BITS:0] d);
    logic [COORD_BITS:0] n;
    n = -d;
    return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  assign hi_w   = prod_r[PROD_BITS-1:COORD_BITS];
  assign rem_sh = {rem_r, dvd_r[PROD_BITS-1]};
  assign ge     = rem_sh >= {1'b0, mden_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      I_IDLE: if (req.start) state_nxt = I_MUL;
      I_MUL:  state_nxt = I_PREP;
      I_PREP: state_nxt = (mden_r == '0) ? I_FIN : I_DIV;
      I_DIV:  if (cnt_r == CNT_BITS'(1)) state_nxt = I_FIN;
      I_FIN:  state_nxt = I_IDLE;
      default: state_nxt = I_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= I_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (req.start && state_r == I_IDLE) valid_r <= 1'b0;
      else if (state_r == I_FIN)          valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      I_IDLE: if (req.start) begin
        mdy_r  <= mag_of(d_dy);
        mnum_r <= mag_of(d_num);
        mden_r <= mag_of(d_den);
        neg_r  <= d_dy[COORD_BITS] ^ d_num[COORD_BITS] ^ d_den[COORD_BITS];
        py_r   <= req.py;
      end
      I_MUL: prod_r <= PROD_BITS'(mdy_r) * PROD_BITS'(mnum_r);
      I_PREP: begin
        q_r <= '0;
        if (hi_w < mden_r) begin
          // high quotient half is zero: start on the low half
          rem_r <= hi_w;
          dvd_r <= {prod_r[COORD_BITS-1:0], {COORD_BITS{1'b0}}};
          cnt_r <= CNT_BITS'(COORD_BITS);
        end else begin
          rem_r <= '0;
          dvd_r <= prod_r;
          cnt_r <= CNT_BITS'(PROD_BITS);
        end
      end
      I_DIV: begin
        rem_r <= ge ? rem_sh[COORD_BITS-1:0] - mden_r : rem_sh[COORD_BITS-1:0];
        q_r   <= {q_r[COORD_BITS-2:0], ge};
        dvd_r <= {dvd_r[PROD_BITS-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_BITS'(1);
      end
      I_FIN: y_r <= neg_r ? py_r - coord_t'(q_r) : py_r + coord_t'(q_r);
      default: ;
    endcase
  end

  assign resp.busy  = (state_r != I_IDLE);
  assign resp.valid = valid_r;
  assign resp.y     = y_r;

endmodule

`default_nettype wire

// File: bench/polyline_clip_x_band_tb.sv
// Self-checking bench for polyline_clip_x_band: directed, band-extreme and random items.
// Uses pcxb_pkg for widths, coordinate type and register indexes; needs only the RTL.
`timescale 1ns / 1ps

module polyline_clip_x_band_tb;
  import pcxb_pkg::*;

  localparam coord_t XY_MAX = 32'sh7FFF_FFFF;
  localparam coord_t XY_MIN = 32'sh8000_0000;
  localparam int     SETTLE_CYCLES = 100;
  localparam int     DRAIN_CAP     = 20000;

  // one clipped output point or break marker
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   gap;
    logic   last;
  } clip_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [TDATA_BITS-1:0]   in_tdata;    // pos_x, pos_y
  logic                    in_tuser;    // is_gap
  logic                    in_tlast;    // end_of_set
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [TDATA_BITS-1:0]   out_tdata;   // out_x, out_y
  logic                    out_tuser;   // out_gap
  logic                    out_tlast;   // last_of_burst
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0]   cfg_data;

  // clipper state as the bench tracks it
  coord_t band_lo, band_hi;
  coord_t prev_x, prev_y;
  logic   prev_valid, prev_inside, break_owed;

  clip_result_t clipped_points [$];   // owed results, oldest first

  int send_idle_pct = 0;   // chance per cycle that the sender holds off
  int stall_pct     = 0;   // chance per cycle that the receiver stalls
  int n_items, n_results, n_crossings, n_breaks, n_errors;

  polyline_clip_x_band uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver back-pressure, redrawn every falling edge.
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= stall_pct);
  end

  function automatic coord_t deg(input int d);
    return coord_t'(d * 4194304);   // whole degrees in Q9.22
  endfunction

  // y where segment p->c meets x = bnd; exact product, quotient truncated toward zero
  function automatic coord_t bound_y(input coord_t px, py, cx, cy, bnd);
    logic signed [COORD_BITS:0] dy, dn, dd;
    logic [COORD_BITS:0]        my, mn, md;
    logic [127:0]               quo;
    dy = $signed({cy[COORD_BITS-1], cy}) - $signed({py[COORD_BITS-1], py});
    dn = $signed({bnd[COORD_BITS-1], bnd}) - $signed({px[COORD_BITS-1], px});
    dd = $signed({cx[COORD_BITS-1], cx}) - $signed({px[COORD_BITS-1], px});
    my = dy[COORD_BITS] ? -dy : dy;
    mn = dn[COORD_BITS] ? -dn : dn;
    md = dd[COORD_BITS] ? -dd : dd;
    if (md == 0) return py;   // equal x, should never happen at a real crossing
    quo = (128'(my) * 128'(mn)) / 128'(md);
    if (dy[COORD_BITS] ^ dn[COORD_BITS] ^ dd[COORD_BITS])
      return py - coord_t'(quo[COORD_BITS-1:0]);
    return py + coord_t'(quo[COORD_BITS-1:0]);
  endfunction

  function automatic void clear_track();
    prev_x      = '0;
    prev_y      = '0;
    prev_valid  = 1'b0;
    prev_inside = 1'b0;
    break_owed  = 1'b0;
  endfunction

  // Advance the tracked state by one accepted item and queue what it should emit.
  task automatic clip_step(input coord_t x, input coord_t y, input logic gap,
                           input logic eos);
    clip_result_t burst [3];
    int           n;
    logic         in_band;
    coord_t       bnd;
    n = 0;
    if (gap) begin
      // a gap closes an inside run; the break marker is held until the next run
      if (prev_valid && prev_inside) break_owed = 1'b1;
      prev_valid  = 1'b0;
      prev_inside = 1'b0;
    end else begin
      in_band = (x >= band_lo) && (x <= band_hi);   // bounds count as inside
      if (in_band) begin
        if (!(prev_valid && prev_inside)) begin
          if (break_owed) begin
            burst[n] = '{'0, '0, 1'b1, 1'b0};
            n++;
            n_breaks++;
            break_owed = 1'b0;
          end
          if (prev_valid) begin
            // entering from an outside point: bound on the side it came from
            bnd = (prev_x < band_lo) ? band_lo : band_hi;
            burst[n] = '{bnd, bound_y(prev_x, prev_y, x, y, bnd), 1'b0, 1'b0};
            n++;
            n_crossings++;
          end
        end
        burst[n] = '{x, y, 1'b0, 1'b0};
        n++;
      end else if (prev_valid && prev_inside) begin
        bnd = (x < band_lo) ? band_lo : band_hi;
        burst[n] = '{bnd, bound_y(prev_x, prev_y, x, y, bnd), 1'b0, 1'b0};
        n++;
        n_crossings++;
        break_owed = 1'b1;
      end
      // outside to outside, even straight across the band, gives nothing
      prev_x      = x;
      prev_y      = y;
      prev_valid  = 1'b1;
      prev_inside = in_band;
    end
    for (int i = 0; i < n; i++) begin
      burst[i].last = (i == n - 1);
      clipped_points.push_back(burst[i]);
    end
    if (eos) clear_track();   // an owed break marker dies with the set
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, want %h (t=%0t)", what, got, want, $time);
    n_errors++;
  endtask

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with valid still high so a following item goes out back to back.
  task automatic send_item(input coord_t x, input coord_t y, input logic gap,
                           input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {y, x};
    in_tuser  = gap;
    in_tlast  = eos;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    clip_step(x, y, gap, eos);
    n_items++;
    @(negedge clk);
  endtask

  // x mostly around the band so entries and exits are common
  function automatic coord_t pick_x();
    longint lo, hi, span, v;
    lo   = band_lo;
    hi   = band_hi;
    span = hi - lo;
    if (span < 64) span = 64;
    case ($urandom_range(9))
      0: return coord_t'($urandom);
      1: return band_lo;
      2: return band_hi;
      default: v = lo - span / 4 + longint'({$urandom, $urandom} >> 1) % (span + span / 2 + 1);
    endcase
    if (v < longint'(XY_MIN)) v = longint'(XY_MIN);
    if (v > longint'(XY_MAX)) v = longint'(XY_MAX);
    return coord_t'(v[COORD_BITS-1:0]);
  endfunction

  // y of any magnitude, from full range down to 8 bits
  function automatic coord_t pick_y();
    return $signed($urandom) >>> $urandom_range(0, 24);
  endfunction

  task automatic send_random_item();
    logic gap, eos;
    gap = ($urandom_range(99) < 8);
    eos = ($urandom_range(99) < 3);
    send_item(pick_x(), pick_y(), gap, eos);
  endtask

  // Stop sending and let every owed result and any divide in flight finish.
  task automatic settle();
    int waited;
    in_tvalid = 1'b0;
    waited    = 0;
    while (clipped_points.size() != 0 && waited < DRAIN_CAP) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only while idle; the clipper's point state is left as it is.
  task automatic write_band(input coord_t lo, input coord_t hi);
    cfg_we    = 1'b1;
    cfg_index = REG_BAND_LOW;
    cfg_data  = lo;
    @(negedge clk);
    cfg_index = REG_BAND_HIGH;
    cfg_data  = hi;
    @(negedge clk);
    cfg_we    = 1'b0;
    band_lo   = lo;
    band_hi   = hi;
  endtask

  // Hand-picked walk through the clipping cases at the reset band of +/-180 degrees.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(deg(0), deg(5), 1'b0, 1'b0);           // first point, inside
    send_item(deg(170), deg(7), 1'b0, 1'b0);
    send_item(deg(200), deg(20), 1'b0, 1'b0);        // exit over the high bound
    send_item(deg(250), deg(-30), 1'b0, 1'b0);       // still outside
    send_item(deg(190), deg(-3), 1'b0, 1'b0);
    send_item(deg(100), deg(1), 1'b0, 1'b0);         // break, entry, point
    send_item(deg(-7), deg(3), 1'b0, 1'b0);
    send_item(XY_MAX, XY_MIN, 1'b1, 1'b0);           // gap after an inside point
    send_item(XY_MIN, XY_MAX, 1'b1, 1'b0);           // repeated gap
    send_item(deg(-200), deg(0), 1'b0, 1'b0);
    send_item(deg(-180), deg(4), 1'b0, 1'b0);        // lands on the low bound
    send_item(deg(180), deg(-4), 1'b0, 1'b0);        // lands on the high bound
    send_item(deg(-300), deg(9), 1'b0, 1'b0);        // exit low
    send_item(deg(300), deg(2), 1'b0, 1'b0);         // jumps across, no output
    send_item(deg(-100), deg(-8), 1'b0, 1'b0);       // entry from the high side
    send_item(deg(400), deg(6), 1'b0, 1'b1);         // exit, owed break dropped at set end
    send_item(deg(10), deg(1), 1'b0, 1'b0);          // fresh set, plain point
    send_item(XY_MAX, XY_MAX, 1'b0, 1'b0);           // widest exit
    send_item(coord_t'(0), XY_MIN, 1'b0, 1'b0);      // widest entry
    send_item(XY_MIN, XY_MAX, 1'b0, 1'b0);
    send_item(deg(-1), XY_MIN, 1'b0, 1'b0);
    send_item(deg(0), XY_MAX, 1'b0, 1'b1);           // inside point ending the set
  endtask

  // Full range, single-value, empty and very narrow bands.
  task automatic test_band_extremes();
    coord_t lows [4];
    coord_t highs [4];
    lows  = '{XY_MIN, deg(5), deg(10), deg(-1)};
    highs = '{XY_MAX, deg(5), deg(-10), deg(1)};
    send_idle_pct = 20;
    stall_pct     = 20;
    for (int b = 0; b < 4; b++) begin
      settle();
      write_band(lows[b], highs[b]);
      send_item(XY_MIN, XY_MAX, 1'b0, 1'b0);
      send_item(lows[b], XY_MIN, 1'b0, 1'b0);
      send_item(XY_MAX, deg(3), 1'b0, 1'b0);
      send_item(highs[b], deg(-3), 1'b0, 1'b0);
      repeat (12) send_random_item();
    end
  endtask

  // Random traffic in four pacing phases, each with its own band.
  task automatic test_random_traffic();
    int     sidle [4];
    int     rstall [4];
    coord_t a, c;
    sidle  = '{0, 53, 0, 20};
    rstall = '{0, 0, 53, 20};
    for (int p = 0; p < 4; p++) begin
      settle();
      send_idle_pct = sidle[p];
      stall_pct     = rstall[p];
      a = $urandom;
      c = $urandom;
      case (p)
        0: write_band(BAND_LOW_RST, BAND_HIGH_RST);
        2: write_band(a >>> 2, (a >>> 2) + coord_t'($urandom_range(1 << 16, 1 << 28)));
        default: write_band((a < c) ? a : c, (a < c) ? c : a);
      endcase
      repeat (46) send_random_item();
    end
  endtask

  // Each result must match the oldest owed one, field by field.
  always @(posedge clk) begin : check_results
    clip_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (clipped_points.size() == 0) begin
        report_mismatch("unowed result", 64'(out_tdata), 64'(0));
      end else begin
        want = clipped_points.pop_front();
        if (out_tdata[COORD_BITS-1:0] !== want.x)
          report_mismatch("out_x", 64'(out_tdata[COORD_BITS-1:0]), 64'(want.x));
        if (out_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y)
          report_mismatch("out_y", 64'(out_tdata[2*COORD_BITS-1:COORD_BITS]),
                          64'(want.y));
        if (out_tuser !== want.gap)
          report_mismatch("out_gap", 64'(out_tuser), 64'(want.gap));
        if (out_tlast !== want.last)
          report_mismatch("last_of_burst", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_BAND_LOW;
    cfg_data  = '0;
    band_lo   = BAND_LOW_RST;
    band_hi   = BAND_HIGH_RST;
    clear_track();
    n_items     = 0;
    n_results   = 0;
    n_crossings = 0;
    n_breaks    = 0;
    n_errors    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_band_extremes();
    test_random_traffic();
    settle();
    if (clipped_points.size() != 0)
      report_mismatch("results never delivered", 64'(clipped_points.size()), 64'(0));

    $display("Run covered %0d items and %0d results: %0d bound crossings, %0d break markers,",
             n_items, n_results, n_crossings, n_breaks);
    $display("reset, full, single-value, empty and random bands under four pacing mixes.");
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
